// File: hdl/bms_pkg.sv
// shared constants and types for the block median smoother
package bms_pkg;

   localparam int MaxBlock    = 16;
   localparam int SampleWidth = 32;
   localparam int SizeWidth   = 5;
   localparam int CountWidth  = $clog2(MaxBlock + 1);
   localparam int HalfCount   = MaxBlock / 2 + 1;
   localparam int HalfWidth   = CountWidth - 1;
   localparam logic [SizeWidth-1:0] SizeReset = SizeWidth'(4);

   typedef logic [SampleWidth-1:0] sample_type;

   // what one cell shows its upper neighbor
   typedef struct packed {
      sample_type value;
      logic       valid;
      logic       gt;
   } bms_link_type;

endpackage

// File: hdl/bms_req_if.sv
// input channel: one sample item per handshake
interface bms_req_if import bms_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

// File: hdl/bms_rsp_if.sv
// result channel: one median item per closed block
interface bms_rsp_if import bms_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type median;
   logic       empty_block;

   modport source (output valid, output median, output empty_block, input ready);
   modport sink (input valid, input median, input empty_block, output ready);
endinterface

// File: hdl/bms_cell.sv
// one slot of the sorted insertion chain
module bms_cell import bms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sample_type   sample,
   input  logic         insert,
   input  logic         clear,
   input  bms_link_type prev,
   output bms_link_type self,
   output sample_type   snap_value
);

   sample_type value_ff, value_in;
   logic       valid_ff, valid_in;
   logic       gt;

   // this slot holds a value above the new sample
   assign gt = valid_ff && (value_ff > sample);

   // shift up from the lower neighbor or take the sample
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (insert) begin
         if (gt) begin
            value_in = prev.gt ? prev.value : sample;
            valid_in = 1'b1;
         end else if (!valid_ff && prev.valid) begin
            // first free slot: takes the shifted top value or the sample itself
            value_in = prev.gt ? prev.value : sample;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= clear ? 1'b0 : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign self.value = value_ff;
   assign self.valid = valid_ff;
   assign self.gt    = gt;
   assign snap_value = value_in;

endmodule

// File: hdl/bms_median.sv
// picks the middle pair of a closed block and forms the median
module bms_median import bms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sample_type            in_value [MaxBlock],
   input  logic [CountWidth-1:0] in_count,
   bms_rsp_if.source             rsp
);

   sample_type             hi_pick [HalfCount];
   sample_type             lo_pick [HalfCount];
   logic [HalfWidth-1:0]   mid;
   sample_type             hi_ff, lo_ff;
   logic                   odd_ff, empty_ff;
   logic                   sel_valid_ff;
   logic                   sel_move, out_move;
   logic [SampleWidth:0]   sum;
   sample_type             median_ff, median_in;
   logic                   empty_block_ff;
   logic                   out_valid_ff;

   // stall chain from the result side back
   assign out_move = !out_valid_ff || rsp.ready;
   assign sel_move = !sel_valid_ff || out_move;
   assign in_ready = sel_move;

   // fixed wiring of the middle pairs, one address picks both
   always_comb begin
      for (int j = 0; j < HalfCount; j++) begin
         hi_pick[j] = in_value[(j < MaxBlock) ? j : MaxBlock - 1];
         lo_pick[j] = in_value[(j > 0) ? j - 1 : 0];
      end
   end

   assign mid = in_count[CountWidth-1:1];

   // select stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (sel_move) begin
         sel_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_move && in_valid) begin
         hi_ff    <= hi_pick[mid];
         lo_ff    <= lo_pick[mid];
         odd_ff   <= in_count[0];
         empty_ff <= (in_count == '0);
      end
   end

   // mean of the middle pair, truncating
   assign sum = {1'b0, hi_ff} + {1'b0, lo_ff};

   always_comb begin
      if (empty_ff) begin
         median_in = '0;
      end else if (odd_ff) begin
         median_in = hi_ff;
      end else begin
         median_in = sum[SampleWidth:1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_move) begin
         out_valid_ff <= sel_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && sel_valid_ff) begin
         median_ff      <= median_in;
         empty_block_ff <= empty_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.median      = median_ff;
   assign rsp.empty_block = empty_block_ff;

endmodule

// File: hdl/block_median_smoother.sv
// top level of the block median smoother
//
//   port     dir  handshake      content
//   req_port in   valid/ready    sample, last
//   rsp_port out  valid/ready    median, empty_block
//   csr_*    in   write enable   block_size
//
// one item per cycle unless stalled; a non-negative sample enters the sorted chain as taken
// a closing item's median passes the snapshot, pair select and output registers in turn
// reset clears the chain's valid bits, the counters and the pipeline at once
// a stalled result backs up through the pipeline; items are still taken while any stage
// has room
module block_median_smoother import bms_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bms_req_if.sink              req_port,
   bms_rsp_if.source            rsp_port,
   input  logic                 csr_write,
   input  logic [SizeWidth-1:0] csr_data
);

   logic [SizeWidth-1:0]  size_ff;
   logic [CountWidth-1:0] eff_size;
   logic [CountWidth-1:0] pos_ff, pos_next;
   logic [CountWidth-1:0] kept_ff, kept_next;
   logic                  accept, keep, close;
   bms_link_type          links [MaxBlock+1];
   sample_type            snap_value [MaxBlock];
   logic [MaxBlock-1:0]   cell_valid;
   sample_type            a_value_ff [MaxBlock];
   logic [CountWidth-1:0] a_count_ff;
   logic                  a_valid_ff, a_move, med_ready;

   // block size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (csr_write) begin
         size_ff <= csr_data;
      end
   end

   // size zero acts as one, large sizes saturate
   always_comb begin
      if (size_ff == '0) begin
         eff_size = CountWidth'(1);
      end else if (int'(size_ff) > MaxBlock) begin
         eff_size = CountWidth'(MaxBlock);
      end else begin
         eff_size = CountWidth'(size_ff);
      end
   end

   assign a_move         = !a_valid_ff || med_ready;
   assign req_port.ready = a_move;
   assign accept         = req_port.valid && a_move;
   assign keep = accept && !req_port.sample[SampleWidth-1] &&
                 (kept_ff != CountWidth'(MaxBlock));
   assign pos_next = (pos_ff < CountWidth'(MaxBlock)) ? pos_ff + 1'b1 : pos_ff;
   assign kept_next = kept_ff + CountWidth'(keep);
   assign close = accept && (req_port.last || (pos_next >= eff_size));

   // block counters
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         kept_ff <= '0;
      end else if (accept) begin
         pos_ff  <= close ? '0 : pos_next;
         kept_ff <= close ? '0 : kept_next;
      end
   end

   // sorted insertion chain
   assign links[0] = '{value: '0, valid: 1'b1, gt: 1'b0};

   for (genvar i = 0; i < MaxBlock; i++) begin : g_cell
      bms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .sample     (req_port.sample),
         .insert     (keep),
         .clear      (close),
         .prev       (links[i]),
         .self       (links[i+1]),
         .snap_value (snap_value[i])
      );
      assign cell_valid[i] = links[i+1].valid;
   end

   // snapshot of a closed block
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_move) begin
         a_valid_ff <= close;
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         a_value_ff <= snap_value;
         a_count_ff <= kept_next;
      end
   end

   bms_median u_median (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_valid_ff),
      .in_ready (med_ready),
      .in_value (a_value_ff),
      .in_count (a_count_ff),
      .rsp      (rsp_port)
   );

`ifndef SYNTHESIS
   // chain occupancy follows the kept counter
   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(kept_ff))
      else $error("chain occupancy differs from kept count");

   // a closing item empties the block
   assert property (@(posedge clock) disable iff (reset)
      close |=> (pos_ff == '0) && (kept_ff == '0))
      else $error("block state not cleared after close");

   // never more kept than seen
   assert property (@(posedge clock) disable iff (reset)
      kept_ff <= pos_ff)
      else $error("kept count exceeds block position");

   // a waiting snapshot is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !med_ready |=> a_valid_ff && $stable(a_count_ff))
      else $error("snapshot lost under stall");
`endif

endmodule
